/* rtl/core/stable_priority_queue_defines.svh */
// Assertion macros used by the checker of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the cycle that follows the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

`endif

/* rtl/core/spq_pkg.sv */
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int ID_WIDTH    = 16;
   localparam int PRIO_WIDTH  = 8;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int IDX_WIDTH   = $clog2(DEPTH);

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      STATE_IDLE   = 1'b0,
      STATE_UPDATE = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [ID_WIDTH-1:0]   entry_id;
      logic [PRIO_WIDTH-1:0] entry_priority;
   } req_type;

   typedef struct packed {
      logic                   popped_valid;
      logic [ID_WIDTH-1:0]    popped_id;
      logic [PRIO_WIDTH-1:0]  popped_priority;
      logic [ID_WIDTH-1:0]    head_id;
      logic [PRIO_WIDTH-1:0]  head_priority;
      logic [ID_WIDTH-1:0]    tail_id;
      logic [PRIO_WIDTH-1:0]  tail_priority;
      logic [COUNT_WIDTH-1:0] entry_count;
      logic                   is_empty;
      status_type             status;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
   } slot_type;

   typedef struct packed {
      logic load;
      logic update;
   } ctrl_type;

endpackage

/* rtl/core/stable_priority_queue.sv */
// Sorted priority queue of up to sixteen (id, priority) entries, highest priority
// at the head and equal priorities served in arrival order. A request is taken
// when start is high while busy is low; busy is then high for one cycle while the
// slot registers are updated, and the response appears on rsp_data for exactly one
// cycle with rsp_strobe high, in the cycle that follows the busy cycle. The receiver
// cannot stall the response, so it must take it in that cycle. A new request may be
// issued in the same cycle as the response; each request is first captured in the
// request register and then written into the slot array while busy is high. A
// pop from an empty queue and a push to a full queue leave the store unchanged and
// are reported in the status field.
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   ctrl_type ctrl;

   spq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctrl       (ctrl)
   );

   spq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/core/spq_controller.sv */
module spq_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output spq_pkg::ctrl_type ctrl
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= STATE_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= ctrl.update;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ctrl.load   = 1'b0;
      ctrl.update = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = STATE_UPDATE;
            end
         end
         STATE_UPDATE: begin
            busy        = 1'b1;
            ctrl.update = 1'b1;
            state_in    = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

/* rtl/core/spq_datapath.sv */
module spq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::ctrl_type ctrl,
   input  spq_pkg::req_type  req_data,
   output spq_pkg::rsp_type  rsp_data
);
   import spq_pkg::*;

   req_type                req_ff;
   slot_type               slots_ff [DEPTH];
   slot_type               slots_in [DEPTH];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [DEPTH-1:0]       stays;
   logic [COUNT_WIDTH-1:0] last_count;
   logic [IDX_WIDTH-1:0]   tail_idx;
   slot_type               new_slot;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         req_ff <= req_data;
      end
      if (ctrl.update) begin
         slots_ff <= slots_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.update) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      new_slot.id   = req_ff.entry_id;
      new_slot.prio = req_ff.entry_priority;
      for (int i = 0; i < DEPTH; i++) begin
         stays[i] = (COUNT_WIDTH'(i) < count_ff) && (slots_ff[i].prio >= new_slot.prio);
      end
   end

   always_comb begin
      slots_in               = slots_ff;
      count_in               = count_ff;
      rsp_in                 = '0;
      rsp_in.status          = STATUS_OK;
      if (req_ff.cmd == CMD_PUSH) begin
         if (count_ff == COUNT_WIDTH'(DEPTH)) begin
            rsp_in.status = STATUS_PUSH_FULL;
         end else begin
            if (!stays[0]) begin
               slots_in[0] = new_slot;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!stays[i]) begin
                  slots_in[i] = stays[i-1] ? new_slot : slots_ff[i-1];
               end
            end
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end else begin
         if (count_ff == '0) begin
            rsp_in.status = STATUS_POP_EMPTY;
         end else begin
            rsp_in.popped_valid    = 1'b1;
            rsp_in.popped_id       = slots_ff[0].id;
            rsp_in.popped_priority = slots_ff[0].prio;
            for (int i = 0; i < DEPTH - 1; i++) begin
               slots_in[i] = slots_ff[i+1];
            end
            count_in = count_ff - COUNT_WIDTH'(1);
         end
      end
      last_count = count_in - COUNT_WIDTH'(1);
      tail_idx   = last_count[IDX_WIDTH-1:0];
      if (count_in != '0) begin
         rsp_in.head_id       = slots_in[0].id;
         rsp_in.head_priority = slots_in[0].prio;
         rsp_in.tail_id       = slots_in[tail_idx].id;
         rsp_in.tail_priority = slots_in[tail_idx].prio;
      end
      rsp_in.entry_count = count_in;
      rsp_in.is_empty    = (count_in == '0);
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/core/spq_checker.sv */
`include "stable_priority_queue_defines.svh"

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input spq_pkg::req_type req_data,
   input logic             rsp_strobe,
   input spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic accepted;

   assign accepted = start && !busy;

   `SPQ_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy)
   `SPQ_ASSERT_NEXT(a_busy_response, clock, reset, busy, rsp_strobe && !busy)
   `SPQ_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `SPQ_ASSERT_NOW(a_empty_count, clock, reset, rsp_strobe,
      rsp_data.is_empty == (rsp_data.entry_count == '0))
   `SPQ_ASSERT_NOW(a_error_no_pop, clock, reset,
      rsp_strobe && (rsp_data.status != STATUS_OK), !rsp_data.popped_valid)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
